>>> sv/ekm_pkg.sv
// Shared types, constants and the encoder transition table for the knob menu controller.
`timescale 1ns / 1ps

package ekm_pkg;

	// Item commands.
	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_VOL_KNOB  = 3'd1,
		CMD_TUNE_KNOB = 3'd2,
		CMD_KNOB1     = 3'd3,
		CMD_KNOB2     = 3'd4,
		CMD_SOURCE    = 3'd5,
		CMD_TIMEOUT   = 3'd6,
		CMD_UNUSED    = 3'd7
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_DEBOUNCE   = 3'd0,
		REG_LONG_PRESS = 3'd1,
		REG_STREAK     = 3'd2,
		REG_TUNE_MIN   = 3'd3,
		REG_TUNE_MAX   = 3'd4,
		REG_TUNE_STEP  = 3'd5,
		REG_SPARE6     = 3'd6,
		REG_SPARE7     = 3'd7
	} reg_idx_t;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// Screen and source codes.
	localparam logic [1:0] SCR_STATUS = 2'd0;
	localparam logic [1:0] SCR_VOLUME = 2'd1;
	localparam logic [1:0] SCR_BASS   = 2'd2;
	localparam logic [1:0] SCR_TREBLE = 2'd3;
	localparam logic [1:0] SRC_FM     = 2'd3;

	// Knob directions.
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	// Held-button bits.
	localparam int unsigned HELD_SOURCE = 0;
	localparam int unsigned HELD_KNOB1  = 1;
	localparam int unsigned HELD_KNOB2  = 2;

	// Change mask bits.
	localparam int unsigned CHG_VOLUME = 0;
	localparam int unsigned CHG_BASS   = 1;
	localparam int unsigned CHG_TREBLE = 2;
	localparam int unsigned CHG_TUNE   = 3;
	localparam int unsigned CHG_SOURCE = 4;
	localparam int unsigned CHG_SCREEN = 5;

	localparam logic [7:0]  VOL_MAX    = 8'd248;
	localparam logic [7:0]  VOL_STEP   = 8'd8;
	localparam logic [4:0]  EQ_MAX     = 5'd24;
	localparam logic [4:0]  EQ_FLAT    = 5'd12;
	localparam logic [10:0] TUNE_RESET = 11'd999;

	localparam logic [15:0] DEBOUNCE_RESET   = 16'd63;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd65535;
	localparam logic [3:0]  STREAK_RESET     = 4'd3;
	localparam logic [10:0] TUNE_MIN_RESET   = 11'd879;
	localparam logic [10:0] TUNE_MAX_RESET   = 11'd1079;
	localparam logic [3:0]  TUNE_STEP_RESET  = 4'd2;

	typedef struct packed {
		logic [1:0] dir;      // raw transition direction
		logic [1:0] pdir;     // updated previous direction
		logic [7:0] streak;   // updated streak count
		logic [1:0] step;     // knob step fired, or none
	} decode_t;

	// Direction of one quadrature transition from the previous phase to the next.
	function automatic logic [1:0] phase_dir(input logic [1:0] prev, input logic [1:0] nxt);
		logic [1:0] d;
		case ({prev, nxt})
			4'b0001: d = DIR_DOWN;
			4'b0010: d = DIR_UP;
			4'b0100: d = DIR_UP;
			4'b0111: d = DIR_DOWN;
			4'b1000: d = DIR_DOWN;
			4'b1011: d = DIR_UP;
			4'b1101: d = DIR_UP;
			4'b1110: d = DIR_DOWN;
			default: d = DIR_NONE;
		endcase
		return d;
	endfunction

	// One encoder sample: a run of same-direction transitions above the threshold
	// makes one step and restarts the run.
	function automatic decode_t decode(input logic [1:0] prev, input logic [1:0] nxt,
			input logic [1:0] pdir, input logic [7:0] streak, input logic [3:0] thr);
		decode_t r;
		logic [7:0] inc;
		r.dir    = phase_dir(prev, nxt);
		r.pdir   = pdir;
		r.streak = streak;
		r.step   = DIR_NONE;
		inc      = streak + 8'd1;
		if (r.dir != DIR_NONE) begin
			if (r.dir == pdir) begin
				if (inc > {4'd0, thr}) begin
					r.pdir   = DIR_NONE;
					r.streak = 8'd0;
					r.step   = r.dir;
				end else begin
					r.streak = inc;
				end
			end else begin
				r.pdir = r.dir;
			end
		end
		return r;
	endfunction

endpackage

>>> sv/encoder_knob_menu_controller_top.sv
// Front-panel knob and button controller: decoding, debounce, menu state and register port.
//
// Usage: each input item carries a command (timer tick, volume or tune knob
// sample, knob 1 or knob 2 press edge, source button level, volume timeout)
// with the pin levels it needs. Every accepted item yields exactly one result
// item on the output channel: the current volume, bass, treble, tuner value,
// source and screen after the item, plus a change mask and a timeout-restart
// flag set by that item alone.
// A result is valid in the cycle after its item is accepted. Throughput is
// one item per cycle; the state registers double as the result register, so
// the next item is taken in the same cycle that the current result is taken.
// When the receiver stalls, the result holds and the input is not ready
// until the result leaves.
// Reset clears the timer, flag, knob and button state, sets the screen to
// status, the source to aux, volume to zero, bass and treble to flat, the tuner
// to 999, and loads the register defaults. The APB port is always ready and
// should be written only while no item is in flight.
`timescale 1ns / 1ps

module encoder_knob_menu_controller_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  command,
	input  logic                        pin_a,
	input  logic                        pin_b,
	input  logic                        button_level,
	// output channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  volume_level,
	output logic [4:0]                  bass_level,
	output logic [4:0]                  treble_level,
	output logic [10:0]                 tune_value,
	output logic [1:0]                  source_select,
	output logic [1:0]                  screen_mode,
	output logic [5:0]                  change_mask,
	output logic                        timeout_restart,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ekm_pkg::ADDR_W-1:0]  paddr,
	input  logic [ekm_pkg::DATA_W-1:0]  pwdata,
	output logic [ekm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	// configuration registers
	logic [15:0] debounce_ticks_q, long_press_ticks_q;
	logic [3:0]  streak_threshold_q, tune_step_q;
	logic [10:0] tune_min_q, tune_max_q;

	// block state
	logic [15:0] timer_q, timer_n;
	logic        flag_q, flag_n;
	logic [1:0]  vol_phase_q, vol_phase_n, vol_pdir_q, vol_pdir_n;
	logic [7:0]  vol_streak_q, vol_streak_n;
	logic [1:0]  tune_phase_q, tune_phase_n, tune_pdir_q, tune_pdir_n;
	logic [7:0]  tune_streak_q, tune_streak_n;
	logic [2:0]  held_q, held_n;
	logic [1:0]  screen_q, screen_n, source_q, source_n;
	logic [7:0]  volume_q, volume_n;
	logic [4:0]  bass_q, bass_n, treble_q, treble_n;
	logic [10:0] tune_q, tune_n;
	logic [5:0]  chg_q, chg_n;
	logic        restart_q, restart_n;
	logic        out_valid_q;

	logic                 accept;
	logic                 gate;
	logic [16:0]          tick_next;
	logic [11:0]          tune_sum;
	logic [1:0]           sample;
	logic                 wr_en;
	ekm_pkg::reg_idx_t    reg_idx;
	ekm_pkg::decode_t     vol_dec, tune_dec;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign gate      = (timer_q > debounce_ticks_q) || flag_q;
	assign sample    = {pin_a, pin_b};
	assign tick_next = {1'b0, timer_q} + 17'd1;
	assign tune_sum  = {1'b0, tune_q} + {8'd0, tune_step_q};

	assign vol_dec  = ekm_pkg::decode(vol_phase_q, sample, vol_pdir_q, vol_streak_q,
		streak_threshold_q);
	assign tune_dec = ekm_pkg::decode(tune_phase_q, sample, tune_pdir_q, tune_streak_q,
		streak_threshold_q);

	always_comb begin
		timer_n       = timer_q;
		flag_n        = flag_q;
		vol_phase_n   = vol_phase_q;
		vol_pdir_n    = vol_pdir_q;
		vol_streak_n  = vol_streak_q;
		tune_phase_n  = tune_phase_q;
		tune_pdir_n   = tune_pdir_q;
		tune_streak_n = tune_streak_q;
		held_n        = held_q;
		screen_n      = screen_q;
		source_n      = source_q;
		volume_n      = volume_q;
		bass_n        = bass_q;
		treble_n      = treble_q;
		tune_n        = tune_q;
		chg_n         = '0;
		restart_n     = 1'b0;
		case (ekm_pkg::cmd_t'(command))
			ekm_pkg::CMD_TICK: begin
				if (tick_next >= {1'b0, long_press_ticks_q}) begin
					timer_n = '0;
					flag_n  = 1'b1;
				end else begin
					timer_n = tick_next[15:0];
				end
			end
			ekm_pkg::CMD_VOL_KNOB: begin
				if (gate) begin
					vol_phase_n = sample;
					if (vol_dec.dir != ekm_pkg::DIR_NONE) begin
						vol_pdir_n   = vol_dec.pdir;
						vol_streak_n = vol_dec.streak;
						restart_n    = 1'b1;
						timer_n      = '0;
						flag_n       = 1'b0;
						// A repeated direction on the status screen opens the volume screen.
						if (vol_dec.dir == vol_pdir_q && screen_q == ekm_pkg::SCR_STATUS) begin
							screen_n = ekm_pkg::SCR_VOLUME;
							chg_n[ekm_pkg::CHG_SCREEN] = 1'b1;
						end
						if (vol_dec.step != ekm_pkg::DIR_NONE) begin
							chg_n[ekm_pkg::CHG_SCREEN] = 1'b1;
							case (screen_n)
								ekm_pkg::SCR_VOLUME: begin
									if (vol_dec.step == ekm_pkg::DIR_UP
											&& volume_q < ekm_pkg::VOL_MAX) begin
										volume_n = volume_q + ekm_pkg::VOL_STEP;
										chg_n[ekm_pkg::CHG_VOLUME] = 1'b1;
									end else if (vol_dec.step == ekm_pkg::DIR_DOWN
											&& volume_q >= ekm_pkg::VOL_STEP) begin
										volume_n = volume_q - ekm_pkg::VOL_STEP;
										chg_n[ekm_pkg::CHG_VOLUME] = 1'b1;
									end
								end
								ekm_pkg::SCR_BASS: begin
									if (vol_dec.step == ekm_pkg::DIR_UP
											&& bass_q < ekm_pkg::EQ_MAX) begin
										bass_n = bass_q + 5'd1;
										chg_n[ekm_pkg::CHG_BASS] = 1'b1;
									end else if (vol_dec.step == ekm_pkg::DIR_DOWN
											&& bass_q != 5'd0) begin
										bass_n = bass_q - 5'd1;
										chg_n[ekm_pkg::CHG_BASS] = 1'b1;
									end
								end
								ekm_pkg::SCR_TREBLE: begin
									if (vol_dec.step == ekm_pkg::DIR_UP
											&& treble_q < ekm_pkg::EQ_MAX) begin
										treble_n = treble_q + 5'd1;
										chg_n[ekm_pkg::CHG_TREBLE] = 1'b1;
									end else if (vol_dec.step == ekm_pkg::DIR_DOWN
											&& treble_q != 5'd0) begin
										treble_n = treble_q - 5'd1;
										chg_n[ekm_pkg::CHG_TREBLE] = 1'b1;
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
			end
			ekm_pkg::CMD_TUNE_KNOB: begin
				if (gate && source_q == ekm_pkg::SRC_FM) begin
					tune_phase_n = sample;
					if (tune_dec.dir != ekm_pkg::DIR_NONE) begin
						tune_pdir_n   = tune_dec.pdir;
						tune_streak_n = tune_dec.streak;
						timer_n       = '0;
						flag_n        = 1'b0;
						if (tune_dec.step != ekm_pkg::DIR_NONE) begin
							chg_n[ekm_pkg::CHG_SCREEN] = 1'b1;
							if (screen_q == ekm_pkg::SCR_STATUS) begin
								if (tune_dec.step == ekm_pkg::DIR_UP && tune_q < tune_max_q) begin
									tune_n = tune_sum[11] ? '1 : tune_sum[10:0];
									chg_n[ekm_pkg::CHG_TUNE] = 1'b1;
								end else if (tune_dec.step == ekm_pkg::DIR_DOWN
										&& tune_q > tune_min_q) begin
									tune_n = (tune_q >= {7'd0, tune_step_q})
										? tune_q - {7'd0, tune_step_q} : '0;
									chg_n[ekm_pkg::CHG_TUNE] = 1'b1;
								end
							end
						end
					end
				end
			end
			ekm_pkg::CMD_KNOB1, ekm_pkg::CMD_KNOB2: begin
				if (gate) begin
					timer_n = '0;
					flag_n  = 1'b0;
					if (command == ekm_pkg::CMD_KNOB1) begin
						if (held_q[ekm_pkg::HELD_KNOB1]) begin
							// Only a long press switches screens on release.
							if (flag_q) begin
								screen_n = (screen_q == ekm_pkg::SCR_STATUS)
									? ekm_pkg::SCR_BASS : ekm_pkg::SCR_STATUS;
								chg_n[ekm_pkg::CHG_SCREEN] = 1'b1;
							end
							held_n[ekm_pkg::HELD_KNOB1] = 1'b0;
						end else begin
							held_n[ekm_pkg::HELD_KNOB1] = 1'b1;
						end
					end else begin
						if (held_q[ekm_pkg::HELD_KNOB2]) begin
							if (flag_q) begin
								screen_n = (screen_q == ekm_pkg::SCR_STATUS)
									? ekm_pkg::SCR_TREBLE : ekm_pkg::SCR_STATUS;
								chg_n[ekm_pkg::CHG_SCREEN] = 1'b1;
							end
							held_n[ekm_pkg::HELD_KNOB2] = 1'b0;
						end else begin
							held_n[ekm_pkg::HELD_KNOB2] = 1'b1;
						end
					end
				end
			end
			ekm_pkg::CMD_SOURCE: begin
				if (gate) begin
					if (held_q[ekm_pkg::HELD_SOURCE] && button_level) begin
						held_n[ekm_pkg::HELD_SOURCE] = 1'b0;
						source_n = source_q + 2'd1;
						chg_n[ekm_pkg::CHG_SOURCE] = 1'b1;
						chg_n[ekm_pkg::CHG_SCREEN] = 1'b1;
						timer_n  = '0;
						flag_n   = 1'b0;
					end else if (!held_q[ekm_pkg::HELD_SOURCE] && !button_level) begin
						held_n[ekm_pkg::HELD_SOURCE] = 1'b1;
						timer_n  = '0;
						flag_n   = 1'b0;
					end
				end
			end
			ekm_pkg::CMD_TIMEOUT: begin
				if (screen_q == ekm_pkg::SCR_VOLUME) begin
					screen_n = ekm_pkg::SCR_STATUS;
					chg_n[ekm_pkg::CHG_SCREEN] = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			timer_q       <= '0;
			flag_q        <= 1'b0;
			vol_phase_q   <= '0;
			vol_pdir_q    <= ekm_pkg::DIR_NONE;
			vol_streak_q  <= '0;
			tune_phase_q  <= '0;
			tune_pdir_q   <= ekm_pkg::DIR_NONE;
			tune_streak_q <= '0;
			held_q        <= '0;
			screen_q      <= ekm_pkg::SCR_STATUS;
			source_q      <= '0;
			volume_q      <= '0;
			bass_q        <= ekm_pkg::EQ_FLAT;
			treble_q      <= ekm_pkg::EQ_FLAT;
			tune_q        <= ekm_pkg::TUNE_RESET;
			chg_q         <= '0;
			restart_q     <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q   <= 1'b1;
				timer_q       <= timer_n;
				flag_q        <= flag_n;
				vol_phase_q   <= vol_phase_n;
				vol_pdir_q    <= vol_pdir_n;
				vol_streak_q  <= vol_streak_n;
				tune_phase_q  <= tune_phase_n;
				tune_pdir_q   <= tune_pdir_n;
				tune_streak_q <= tune_streak_n;
				held_q        <= held_n;
				screen_q      <= screen_n;
				source_q      <= source_n;
				volume_q      <= volume_n;
				bass_q        <= bass_n;
				treble_q      <= treble_n;
				tune_q        <= tune_n;
				chg_q         <= chg_n;
				restart_q     <= restart_n;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The state registers only move on an accepted item, which happens only once the
	// previous result has left, so they serve as the result register.
	assign out_valid       = out_valid_q;
	assign volume_level    = volume_q;
	assign bass_level      = bass_q;
	assign treble_level    = treble_q;
	assign tune_value      = tune_q;
	assign source_select   = source_q;
	assign screen_mode     = screen_q;
	assign change_mask     = chg_q;
	assign timeout_restart = restart_q;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = ekm_pkg::reg_idx_t'(paddr[ekm_pkg::ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= ekm_pkg::DEBOUNCE_RESET;
			long_press_ticks_q <= ekm_pkg::LONG_PRESS_RESET;
			streak_threshold_q <= ekm_pkg::STREAK_RESET;
			tune_min_q         <= ekm_pkg::TUNE_MIN_RESET;
			tune_max_q         <= ekm_pkg::TUNE_MAX_RESET;
			tune_step_q        <= ekm_pkg::TUNE_STEP_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				ekm_pkg::REG_DEBOUNCE:   debounce_ticks_q   <= pwdata[15:0];
				ekm_pkg::REG_LONG_PRESS: long_press_ticks_q <= pwdata[15:0];
				ekm_pkg::REG_STREAK:     streak_threshold_q <= pwdata[3:0];
				ekm_pkg::REG_TUNE_MIN:   tune_min_q         <= pwdata[10:0];
				ekm_pkg::REG_TUNE_MAX:   tune_max_q         <= pwdata[10:0];
				ekm_pkg::REG_TUNE_STEP:  tune_step_q        <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			ekm_pkg::REG_DEBOUNCE:   prdata = {16'd0, debounce_ticks_q};
			ekm_pkg::REG_LONG_PRESS: prdata = {16'd0, long_press_ticks_q};
			ekm_pkg::REG_STREAK:     prdata = {28'd0, streak_threshold_q};
			ekm_pkg::REG_TUNE_MIN:   prdata = {21'd0, tune_min_q};
			ekm_pkg::REG_TUNE_MAX:   prdata = {21'd0, tune_max_q};
			ekm_pkg::REG_TUNE_STEP:  prdata = {28'd0, tune_step_q};
			default:                 prdata = '0;
		endcase
	end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the front-panel knob and button controller.
`timescale 1ns / 1ps

module testbench;
	import ekm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned ITEM_TARGET = 1150;
	localparam int unsigned PHASE_ITEMS = 130;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam logic [1:0]  SRC_AUX     = 2'd0;

	typedef struct packed {
		logic [7:0]  volume;
		logic [4:0]  bass;
		logic [4:0]  treble;
		logic [10:0] tune;
		logic [1:0]  source;
		logic [1:0]  screen;
		logic [5:0]  change;
		logic        restart;
	} panel_t;

	typedef struct {
		logic [15:0] deb;
		logic [15:0] lp;
		logic [3:0]  thr;
		logic [10:0] tmin;
		logic [10:0] tmax;
		logic [3:0]  tstep;
		int          up_pct;
	} setting_t;

	typedef enum {RX_OPEN, RX_LIGHT, RX_EVERY_THIRD, RX_HEAVY} rx_mode_e;

	class panel_scoreboard;
		logic [15:0] deb = DEBOUNCE_RESET;
		logic [15:0] lp = LONG_PRESS_RESET;
		logic [3:0]  thr = STREAK_RESET;
		logic [10:0] tmin = TUNE_MIN_RESET;
		logic [10:0] tmax = TUNE_MAX_RESET;
		logic [3:0]  tstep = TUNE_STEP_RESET;
		logic [15:0] timer = '0;
		logic        flag = 1'b0;
		logic [1:0]  vol_phase = 2'd0;
		logic [1:0]  vol_pdir = DIR_NONE;
		logic [7:0]  vol_streak = '0;
		logic [1:0]  tune_phase = 2'd0;
		logic [1:0]  tune_pdir = DIR_NONE;
		logic [7:0]  tune_streak = '0;
		logic [2:0]  held = '0;
		logic [1:0]  screen = SCR_STATUS;
		logic [1:0]  source_sel = SRC_AUX;
		logic [7:0]  volume = '0;
		logic [4:0]  bass = EQ_FLAT;
		logic [4:0]  treble = EQ_FLAT;
		logic [10:0] tune = TUNE_RESET;
		panel_t      expected_panel[$];
		int unsigned errors = 0;

		function void set_register(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_DEBOUNCE:   deb = value[15:0];
				REG_LONG_PRESS: lp = value[15:0];
				REG_STREAK:     thr = value[3:0];
				REG_TUNE_MIN:   tmin = value[10:0];
				REG_TUNE_MAX:   tmax = value[10:0];
				REG_TUNE_STEP:  tstep = value[3:0];
				default: ;
			endcase
		endfunction

		// Pin pairs run 00, 10, 11, 01 when turned up; a quarter turn either way
		// is a transition, a half turn or no change is none.
		function logic [1:0] transition_dir(logic [1:0] prev, logic [1:0] nxt);
			logic [1:0] from_pos, to_pos, delta;
			from_pos = {prev[0], prev[1] ^ prev[0]};
			to_pos   = {nxt[0], nxt[1] ^ nxt[0]};
			delta    = to_pos - from_pos;
			if (delta == 2'd1)
				return DIR_UP;
			if (delta == 2'd3)
				return DIR_DOWN;
			return DIR_NONE;
		endfunction

		function logic [1:0] run_encoder(logic a, logic b, inout logic [1:0] phase,
				inout logic [1:0] pdir, inout logic [7:0] streak, output logic [1:0] raw);
			logic [1:0] nxt;
			nxt = {a, b};
			raw = transition_dir(phase, nxt);
			phase = nxt;
			if (raw == DIR_NONE)
				return DIR_NONE;
			if (raw == pdir) begin
				streak = streak + 8'd1;
				if (streak > {4'd0, thr}) begin
					pdir = DIR_NONE;
					streak = '0;
					return raw;
				end
			end else begin
				pdir = raw;
			end
			return DIR_NONE;
		endfunction

		// Advances the panel state by one item and queues the result it yields.
		// Returns whether the item did anything at all.
		function bit note_item(cmd_t cmd, logic a, logic b, logic lvl);
			panel_t      r;
			logic [1:0]  step, raw, dir_before, target;
			logic [16:0] next_timer;
			logic [11:0] tune_sum;
			logic [5:0]  chg;
			logic        restart, gate;
			int          bit_idx;
			bit          acted;
			chg = '0;
			restart = 1'b0;
			acted = 1'b0;
			gate = (timer > deb) || flag;
			case (cmd)
				CMD_TICK: begin
					acted = 1'b1;
					next_timer = {1'b0, timer} + 17'd1;
					if (next_timer >= {1'b0, lp}) begin
						timer = '0;
						flag = 1'b1;
					end else begin
						timer = next_timer[15:0];
					end
				end
				CMD_VOL_KNOB: if (gate) begin
					acted = 1'b1;
					dir_before = vol_pdir;
					step = run_encoder(a, b, vol_phase, vol_pdir, vol_streak, raw);
					if (raw != DIR_NONE) begin
						restart = 1'b1;
						// Two transitions the same way wake the volume screen.
						if (raw == dir_before && screen == SCR_STATUS) begin
							screen = SCR_VOLUME;
							chg[CHG_SCREEN] = 1'b1;
						end
						if (step != DIR_NONE) begin
							chg[CHG_SCREEN] = 1'b1;
							case (screen)
								SCR_VOLUME: begin
									if (step == DIR_UP && volume < VOL_MAX) begin
										volume = volume + VOL_STEP;
										chg[CHG_VOLUME] = 1'b1;
									end else if (step == DIR_DOWN && volume >= VOL_STEP) begin
										volume = volume - VOL_STEP;
										chg[CHG_VOLUME] = 1'b1;
									end
								end
								SCR_BASS: begin
									if (step == DIR_UP && bass < EQ_MAX) begin
										bass = bass + 5'd1;
										chg[CHG_BASS] = 1'b1;
									end else if (step == DIR_DOWN && bass != 5'd0) begin
										bass = bass - 5'd1;
										chg[CHG_BASS] = 1'b1;
									end
								end
								SCR_TREBLE: begin
									if (step == DIR_UP && treble < EQ_MAX) begin
										treble = treble + 5'd1;
										chg[CHG_TREBLE] = 1'b1;
									end else if (step == DIR_DOWN && treble != 5'd0) begin
										treble = treble - 5'd1;
										chg[CHG_TREBLE] = 1'b1;
									end
								end
								default: ;
							endcase
						end
						timer = '0;
						flag = 1'b0;
					end
				end
				CMD_TUNE_KNOB: if (source_sel == SRC_FM && gate) begin
					acted = 1'b1;
					step = run_encoder(a, b, tune_phase, tune_pdir, tune_streak, raw);
					if (raw != DIR_NONE) begin
						if (step != DIR_NONE) begin
							chg[CHG_SCREEN] = 1'b1;
							if (screen == SCR_STATUS) begin
								if (step == DIR_UP && tune < tmax) begin
									tune_sum = {1'b0, tune} + {8'd0, tstep};
									tune = (tune_sum > 12'd2047) ? 11'd2047 : tune_sum[10:0];
									chg[CHG_TUNE] = 1'b1;
								end else if (step == DIR_DOWN && tune > tmin) begin
									tune = (tune >= {7'd0, tstep}) ? tune - {7'd0, tstep} : 11'd0;
									chg[CHG_TUNE] = 1'b1;
								end
							end
						end
						timer = '0;
						flag = 1'b0;
					end
				end
				CMD_KNOB1, CMD_KNOB2: if (gate) begin
					acted = 1'b1;
					bit_idx = (cmd == CMD_KNOB1) ? HELD_KNOB1 : HELD_KNOB2;
					target = (cmd == CMD_KNOB1) ? SCR_BASS : SCR_TREBLE;
					if (held[bit_idx]) begin
						// Only a long hold flips the screen on release.
						if (flag) begin
							screen = (screen == SCR_STATUS) ? target : SCR_STATUS;
							chg[CHG_SCREEN] = 1'b1;
						end
						held[bit_idx] = 1'b0;
					end else begin
						held[bit_idx] = 1'b1;
					end
					timer = '0;
					flag = 1'b0;
				end
				CMD_SOURCE: if (gate) begin
					if (held[HELD_SOURCE] && lvl) begin
						acted = 1'b1;
						held[HELD_SOURCE] = 1'b0;
						source_sel = source_sel + 2'd1;
						chg[CHG_SOURCE] = 1'b1;
						chg[CHG_SCREEN] = 1'b1;
						timer = '0;
						flag = 1'b0;
					end else if (!held[HELD_SOURCE] && !lvl) begin
						acted = 1'b1;
						held[HELD_SOURCE] = 1'b1;
						timer = '0;
						flag = 1'b0;
					end
				end
				CMD_TIMEOUT: if (screen == SCR_VOLUME) begin
					acted = 1'b1;
					screen = SCR_STATUS;
					chg[CHG_SCREEN] = 1'b1;
				end
				default: ;
			endcase
			r.volume = volume;
			r.bass = bass;
			r.treble = treble;
			r.tune = tune;
			r.source = source_sel;
			r.screen = screen;
			r.change = chg;
			r.restart = restart;
			expected_panel.push_back(r);
			return acted;
		endfunction

		function bit same(string what, int unsigned want, int unsigned got);
			if (want == got)
				return 1'b1;
			errors++;
			if (errors <= 40)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			return 1'b0;
		endfunction

		function void check_result(panel_t got);
			panel_t want;
			if (expected_panel.size() == 0) begin
				errors++;
				$display("%0t: result item with nothing expected, expected none, actual %h",
					$time, got);
				return;
			end
			want = expected_panel.pop_front();
			void'(same("volume_level", 32'(want.volume), 32'(got.volume)));
			void'(same("bass_level", 32'(want.bass), 32'(got.bass)));
			void'(same("treble_level", 32'(want.treble), 32'(got.treble)));
			void'(same("tune_value", 32'(want.tune), 32'(got.tune)));
			void'(same("source_select", 32'(want.source), 32'(got.source)));
			void'(same("screen_mode", 32'(want.screen), 32'(got.screen)));
			void'(same("change_mask", 32'(want.change), 32'(got.change)));
			void'(same("timeout_restart", 32'(want.restart), 32'(got.restart)));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] command = CMD_TICK;
	logic pin_a = 1'b0;
	logic pin_b = 1'b0;
	logic button_level = 1'b1;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] volume_level;
	logic [4:0] bass_level;
	logic [4:0] treble_level;
	logic [10:0] tune_value;
	logic [1:0] source_select;
	logic [1:0] screen_mode;
	logic [5:0] change_mask;
	logic timeout_restart;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	panel_scoreboard sb = new;
	setting_t cur = '{DEBOUNCE_RESET, LONG_PRESS_RESET, STREAK_RESET, TUNE_MIN_RESET,
		TUNE_MAX_RESET, TUNE_STEP_RESET, 50};
	int unsigned effective_items = 0;
	int burst_left = 0;
	logic [1:0] knob_pins[2] = '{2'd0, 2'd0};
	bit hold_requested = 1'b0;

	encoder_knob_menu_controller_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.pin_a(pin_a), .pin_b(pin_b), .button_level(button_level),
		.out_valid(out_valid), .out_ready(out_ready),
		.volume_level(volume_level), .bass_level(bass_level), .treble_level(treble_level),
		.tune_value(tune_value), .source_select(source_select), .screen_mode(screen_mode),
		.change_mask(change_mask), .timeout_restart(timeout_restart),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Handshakes are sampled mid-cycle, where every driven input has settled.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{volume_level, bass_level, treble_level, tune_value,
				source_select, screen_mode, change_mask, timeout_restart});
	end

	initial begin : receiver
		rx_mode_e mode;
		int left;
		mode = RX_OPEN;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_requested) begin
				hold_requested = 1'b0;
				out_ready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end
			if (left == 0) begin
				mode = rx_mode_e'($urandom_range(0, 3));
				left = $urandom_range(20, 120);
			end
			left--;
			case (mode)
				RX_OPEN:        out_ready <= 1'b1;
				RX_LIGHT:       out_ready <= ($urandom_range(0, 9) >= 3);
				RX_EVERY_THIRD: out_ready <= (left % 3 == 0);
				default:        out_ready <= ($urandom_range(0, 9) >= 7);
			endcase
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	task automatic send(input cmd_t c, input logic a, input logic b, input logic lvl);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= c;
		pin_a <= a;
		pin_b <= b;
		button_level <= lvl;
		do @(negedge clk); while (!in_ready);
		if (sb.note_item(c, a, b, lvl))
			effective_items++;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_panel.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	task automatic apply_setting(input setting_t s);
		cur = s;
		apb_write(REG_DEBOUNCE, 32'(s.deb));
		apb_write(REG_LONG_PRESS, 32'(s.lp));
		apb_write(REG_STREAK, 32'(s.thr));
		apb_write(REG_TUNE_MIN, 32'(s.tmin));
		apb_write(REG_TUNE_MAX, 32'(s.tmax));
		apb_write(REG_TUNE_STEP, 32'(s.tstep));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic setting_t pick_setting(int n);
		setting_t s;
		case (n)
			0: s = '{16'd0, 16'd4, 4'd0, 11'd0, 11'd2047, 4'd15, 85};
			1: s = '{16'd1, 16'd6, 4'd1, 11'd0, 11'd2047, 4'd15, 15};
			2: s = '{16'd65535, 16'd0, 4'd15, 11'd1000, 11'd1010, 4'd1, 50};
			3: s = '{16'd3, 16'd65535, 4'd3, 11'd879, 11'd1079, 4'd2, 50};
			4: s = '{16'd2, 16'd1, 4'd2, 11'd2047, 11'd0, 4'd7, 50};
			5: s = '{16'd0, 16'd10, 4'd0, 11'd500, 11'd1500, 4'd9, 60};
			default: s = '{16'($urandom_range(0, 4)), 16'($urandom_range(0, 12)),
				4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)),
				11'($urandom_range(0, 2047)), 4'($urandom_range(0, 15)),
				int'($urandom_range(10, 90))};
		endcase
		return s;
	endfunction

	function automatic int long_press_len();
		return (cur.lp == 16'd0) ? 1 : int'(cur.lp);
	endfunction

	function automatic int ticks_to_open();
		return (int'(cur.deb) + 1 < long_press_len()) ? int'(cur.deb) + 1 : long_press_len();
	endfunction

	function automatic logic [1:0] quad_next(logic [1:0] p, bit up);
		case (p)
			2'b00:   return up ? 2'b10 : 2'b01;
			2'b10:   return up ? 2'b11 : 2'b00;
			2'b11:   return up ? 2'b01 : 2'b10;
			default: return up ? 2'b00 : 2'b11;
		endcase
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic open_gate();
		int n;
		n = ticks_to_open();
		// Now and then the event comes one tick too early and must be dropped.
		if ($urandom_range(0, 9) == 0)
			n = n - 1;
		repeat (n) send(CMD_TICK, rand_bit(), rand_bit(), rand_bit());
	endtask

	task automatic turn_knob(input cmd_t c, input int idx);
		int n;
		bit up;
		logic [1:0] nxt;
		n = $urandom_range(1, int'(cur.thr) + 4);
		up = ($urandom_range(1, 100) <= cur.up_pct);
		for (int i = 0; i < n; i++) begin
			open_gate();
			case ($urandom_range(0, 19))
				0: nxt = knob_pins[idx] ^ 2'b11;
				1: nxt = knob_pins[idx];
				2: nxt = quad_next(knob_pins[idx], !up);
				default: nxt = quad_next(knob_pins[idx], up);
			endcase
			knob_pins[idx] = nxt;
			send(c, nxt[1], nxt[0], rand_bit());
		end
	endtask

	task automatic press_knob(input cmd_t c);
		open_gate();
		send(c, rand_bit(), rand_bit(), rand_bit());
		if (long_press_len() <= 40 && $urandom_range(0, 1))
			repeat (long_press_len()) send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		else
			open_gate();
		send(c, rand_bit(), rand_bit(), rand_bit());
	endtask

	task automatic press_source();
		open_gate();
		send(CMD_SOURCE, rand_bit(), rand_bit(), 1'b0);
		if ($urandom_range(0, 3) == 0)
			send(CMD_SOURCE, rand_bit(), rand_bit(), 1'b0);
		open_gate();
		send(CMD_SOURCE, rand_bit(), rand_bit(), 1'b1);
	endtask

	task automatic run_episode();
		int pick;
		bit fm;
		pick = $urandom_range(0, 99);
		// The tune knob only does anything on FM, so lean on it while FM is up.
		fm = (sb.source_sel == SRC_FM);
		if (pick < (fm ? 20 : 40))
			turn_knob(CMD_VOL_KNOB, 0);
		else if (pick < (fm ? 65 : 50))
			turn_knob(CMD_TUNE_KNOB, 1);
		else if (pick < 76)
			press_knob($urandom_range(0, 1) ? CMD_KNOB1 : CMD_KNOB2);
		else if (pick < 88)
			press_source();
		else if (pick < 93)
			send(CMD_TIMEOUT, rand_bit(), rand_bit(), rand_bit());
		else
			send(cmd_t'($urandom_range(0, 7)), rand_bit(), rand_bit(), rand_bit());
	endtask

	initial begin : stimulus
		int unsigned phase_start;
		bit pause_done, hold_done;
		pause_done = 1'b0;
		hold_done = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: the gate is shut, so nothing but the timer moves.
		send(CMD_UNUSED, 1'b1, 1'b1, 1'b0);
		send(CMD_TIMEOUT, 1'b0, 1'b0, 1'b1);
		send(CMD_VOL_KNOB, 1'b1, 1'b0, 1'b1);
		send(CMD_KNOB1, 1'b0, 1'b1, 1'b1);
		send(CMD_SOURCE, 1'b0, 1'b0, 1'b0);
		send(CMD_TICK, 1'b1, 1'b1, 1'b1);
		wait_drained();
		apply_setting('{16'd0, 16'd3, 4'd0, 11'd0, 11'd2047, 4'd15, 50});

		send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		send(CMD_VOL_KNOB, 1'b1, 1'b0, 1'b1);
		send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		send(CMD_VOL_KNOB, 1'b1, 1'b1, 1'b1);
		send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		// Same pins again: no transition, and the open gate stays open.
		send(CMD_VOL_KNOB, 1'b1, 1'b1, 1'b1);
		send(CMD_VOL_KNOB, 1'b1, 1'b0, 1'b1);
		send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		send(CMD_VOL_KNOB, 1'b0, 1'b0, 1'b1);
		send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		send(CMD_VOL_KNOB, 1'b0, 1'b1, 1'b1);
		send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		// A step down at zero volume still asks for a redraw.
		send(CMD_VOL_KNOB, 1'b1, 1'b1, 1'b1);
		send(CMD_TIMEOUT, 1'b0, 1'b0, 1'b1);
		send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		send(CMD_KNOB1, 1'b0, 1'b0, 1'b1);
		send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		send(CMD_KNOB1, 1'b0, 1'b0, 1'b1);
		send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		send(CMD_KNOB2, 1'b0, 1'b0, 1'b1);
		repeat (3) send(CMD_TICK, 1'b1, 1'b0, 1'b0);
		send(CMD_KNOB2, 1'b0, 1'b0, 1'b1);
		send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		send(CMD_SOURCE, 1'b0, 1'b0, 1'b0);
		send(CMD_TICK, 1'b0, 1'b0, 1'b1);
		send(CMD_SOURCE, 1'b0, 1'b0, 1'b0);
		send(CMD_SOURCE, 1'b0, 1'b0, 1'b1);
		send(CMD_UNUSED, 1'b0, 1'b1, 1'b0);

		for (int phase = 0; effective_items < ITEM_TARGET; phase++) begin
			wait_drained();
			apply_setting(pick_setting(phase));
			phase_start = effective_items;
			while (effective_items - phase_start < PHASE_ITEMS && effective_items < ITEM_TARGET) begin
				if (phase == 2 && !pause_done && effective_items - phase_start > 60) begin
					pause_done = 1'b1;
					wait_drained();
				end
				if (phase == 5 && !hold_done && effective_items - phase_start > 40) begin
					hold_done = 1'b1;
					hold_requested = 1'b1;
				end
				run_episode();
			end
		end

		wait_drained();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
